FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; included by name where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define TSW_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsw assertion failed");

// condition must never be true out of reset
`define TSW_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tsw forbidden condition seen");

`endif

FILE: hw/rtl/tsw_pkg.sv
// types and constants of the tcp sender window engine
// no dependencies; used by all rtl modules of the block but tsw_ram
package tsw_pkg;

    localparam int RESULT_CAP = 48;
    localparam int RES_AW     = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RTO   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SEQNO = 1'd1;

    typedef enum logic [1:0] {
        FN_FILL  = 2'd0,
        FN_ACK   = 2'd1,
        FN_TICK  = 2'd2,
        FN_EMPTY = 2'd3
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [31:0] ack_number;
        logic [15:0] peer_window;
        logic [15:0] elapsed_ms;
        logic [15:0] bytes_available;
        logic        stream_eof;
    } in_item_t;

    typedef struct packed {
        logic        has_segment;
        logic [31:0] seg_seqno;
        logic [10:0] seg_length;
        logic        seg_syn;
        logic        seg_fin;
        logic        is_retransmit;
        logic [16:0] in_flight;
        logic [7:0]  retx_count;
        logic        last;
    } out_item_t;

    // outstanding segment descriptor
    typedef struct packed {
        logic [63:0] start;
        logic [15:0] len;
        logic        syn;
        logic        fin;
    } seg_t;

    // one buffered result, before flight and count are known
    typedef struct packed {
        logic        has_segment;
        logic [31:0] seqno;
        logic [10:0] len;
        logic        syn;
        logic        fin;
        logic        retx;
    } rec_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic        sub;
    } alu_op_t;

    // flag: carry out for add, borrow (a < b) for subtract
    typedef struct packed {
        logic [63:0] value;
        logic        flag;
    } alu_res_t;

endpackage

FILE: hw/rtl/tcp_sender_window_retransmit.sv
// channel | dir | handshake             | payload
// in      | in  | in_valid / in_ready   | in_data   (tsw_pkg::in_item_t)
// out     | out | out_valid / out_ready | out_data  (tsw_pkg::out_item_t)
// cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one event at a time through a sequencer around one shared 64-bit adder
// from acceptance: an ack is unwrapped, checked against next, pops acked segments, then
// the fill (a dropped ack skips it); a fill emits segments while space remains;
// a tick adds time when the timer runs; then the total, and each result, held by out_ready
// results are buffered and released once in-flight and retx count are final
// reset clears all control state; no clearing pass, the fifo is read below count
// depends on tsw_pkg, tsw_alu, tsw_ram
module tcp_sender_window_retransmit #(
    parameter int MAX_PAYLOAD   = 1452,
    parameter int PENDING_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  tsw_pkg::in_item_t                in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output tsw_pkg::out_item_t               out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);
    localparam int AW = $clog2(PENDING_DEPTH);
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam logic [15:0] MAX_PL = 16'(MAX_PAYLOAD);

    typedef enum logic [4:0] {
        S_IDLE, S_ACK_UNWRAP, S_ACK_CMP, S_POP_RD, S_POP_END, S_POP_CMP,
        S_ACK_MAX, S_FILL_INIT, S_FILL_CHK, S_FILL_DO, S_FILL_ADV,
        S_TICK_ADD, S_TICK_CMP, S_FLIGHT_WAIT, S_FLIGHT, S_OUT_RD, S_OUT_SHOW
    } state_t;

    state_t                      state_reg;
    logic [15:0]                 init_rto_reg;
    logic [31:0]                 isn_reg;
    logic [63:0]                 next_reg, acked_reg, ack_abs_reg, right_reg, space_reg;
    logic [16:0]                 span_reg;
    logic                        stop_reg;
    logic [15:0]                 window_reg, avail_reg, elapsed_reg, pwin_reg;
    logic [31:0]                 ackn_reg, rto_reg, timer_reg;
    logic                        timer_on_reg, syn_done_reg, fin_done_reg;
    logic                        eof_reg, popped_reg, apply_reg;
    logic [7:0]                  retx_reg;
    logic [AW-1:0]               head_reg;
    logic [CW-1:0]               count_reg;
    logic [tsw_pkg::RES_AW-1:0]  k_reg, out_idx_reg;
    logic [16:0]                 flight_reg;
    logic                        out_valid_reg;

    tsw_pkg::alu_op_t  alu_op;
    tsw_pkg::alu_res_t alu_res;
    tsw_pkg::seg_t     head_seg, fifo_wdata;
    tsw_pkg::rec_t     rbuf_wdata, rbuf_rdata;
    logic              fifo_we, rbuf_we, fill_end, emit_fin;
    logic [tsw_pkg::RES_AW-1:0] rbuf_waddr;
    logic [AW-1:0]     tail;
    logic [CW:0]       tail_sum;
    logic [15:0]       eff_win, cap16, pl16, avail_left;
    logic [16:0]       emit_span, head_span;
    logic [31:0]       off32, lo_diff, hi_adj;
    logic [63:0]       unwrapped;
    logic              retx_go;

    tsw_alu u_alu (.op(alu_op), .res(alu_res));

    tsw_ram #(.WIDTH($bits(tsw_pkg::seg_t)), .DEPTH(PENDING_DEPTH)) u_fifo (
        .clk(clk), .we(fifo_we), .waddr(tail), .wdata(fifo_wdata),
        .re(1'b1), .raddr(head_reg), .rdata(head_seg)
    );

    // the empty segment is written while k_reg still holds the previous count
    assign rbuf_waddr = (state_reg == S_IDLE) ? '0 : k_reg;

    tsw_ram #(.WIDTH($bits(tsw_pkg::rec_t)), .DEPTH(tsw_pkg::RESULT_CAP)) u_rbuf (
        .clk(clk), .we(rbuf_we), .waddr(rbuf_waddr), .wdata(rbuf_wdata),
        .re(state_reg == S_OUT_RD), .raddr(out_idx_reg), .rdata(rbuf_rdata)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_data.has_segment   = rbuf_rdata.has_segment;
        out_data.seg_seqno     = rbuf_rdata.seqno;
        out_data.seg_length    = rbuf_rdata.len;
        out_data.seg_syn       = rbuf_rdata.syn;
        out_data.seg_fin       = rbuf_rdata.fin;
        out_data.is_retransmit = rbuf_rdata.retx;
        out_data.in_flight     = flight_reg;
        out_data.retx_count    = retx_reg;
        out_data.last          = (out_idx_reg == k_reg - tsw_pkg::RES_AW'(1));
    end

    // ack unwrap near the acknowledged point
    always_comb
    begin
        off32   = ackn_reg - isn_reg;
        lo_diff = (off32 > acked_reg[31:0]) ? off32 - acked_reg[31:0]
                                            : acked_reg[31:0] - off32;
        hi_adj  = acked_reg[63:32];
        if (off32 > acked_reg[31:0] && lo_diff > 32'h8000_0000 && acked_reg[63:32] != '0)
        begin
            hi_adj = acked_reg[63:32] - 32'd1;
        end
        else if (off32 < acked_reg[31:0] && lo_diff > 32'h8000_0000
                 && acked_reg[63:32] != '1)
        begin
            hi_adj = acked_reg[63:32] + 32'd1;
        end
        unwrapped = {hi_adj, off32};
    end

    always_comb
    begin
        eff_win    = (window_reg == '0) ? 16'd1 : window_reg;
        cap16      = (space_reg[63:16] == '0 && space_reg[15:0] < MAX_PL)
                     ? space_reg[15:0] : MAX_PL;
        pl16       = (cap16 > avail_reg) ? avail_reg : cap16;
        avail_left = avail_reg - pl16;
        head_span  = {1'b0, head_seg.len} + {16'd0, head_seg.syn} + {16'd0, head_seg.fin};
        tail_sum   = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        tail       = (tail_sum >= (CW+1)'(PENDING_DEPTH))
                     ? AW'(tail_sum - (CW+1)'(PENDING_DEPTH)) : AW'(tail_sum);
        retx_go    = (timer_reg >= rto_reg) && (count_reg != '0);

        fifo_we    = 1'b0;
        fifo_wdata = '0;
        rbuf_we    = 1'b0;
        rbuf_wdata = '0;
        emit_span  = '0;
        emit_fin   = 1'b0;
        fill_end   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_data.func == tsw_pkg::FN_EMPTY)
                begin
                    rbuf_we                = 1'b1;
                    rbuf_wdata.has_segment = 1'b1;
                    rbuf_wdata.seqno       = next_reg[31:0] + isn_reg;
                end
            end
            S_FILL_DO:
            begin
                if (!syn_done_reg)
                begin
                    fifo_we = 1'b1;
                    fifo_wdata.syn = 1'b1;
                    emit_span = 17'd1;
                end
                else if (pl16 == '0)
                begin
                    if (eof_reg && avail_reg == '0 && !fin_done_reg)
                    begin
                        fifo_we = 1'b1;
                        fifo_wdata.fin = 1'b1;
                        emit_fin = 1'b1;
                        emit_span = 17'd1;
                    end
                    else
                    begin
                        fill_end = 1'b1;
                    end
                end
                else
                begin
                    fifo_we = 1'b1;
                    emit_fin = !fin_done_reg && eof_reg && avail_left == '0
                               && (space_reg[63:16] != '0 || space_reg[15:0] != pl16);
                    fifo_wdata.len = pl16;
                    fifo_wdata.fin = emit_fin;
                    emit_span = {1'b0, pl16} + {16'd0, emit_fin};
                end
                fifo_wdata.start       = next_reg;
                rbuf_we                = fifo_we;
                rbuf_wdata.has_segment = 1'b1;
                rbuf_wdata.seqno       = next_reg[31:0] + isn_reg;
                rbuf_wdata.len         = fifo_wdata.len[10:0];
                rbuf_wdata.syn         = fifo_wdata.syn;
                rbuf_wdata.fin         = fifo_wdata.fin;
            end
            S_TICK_CMP:
            begin
                if (retx_go)
                begin
                    rbuf_we                = 1'b1;
                    rbuf_wdata.has_segment = 1'b1;
                    rbuf_wdata.seqno       = head_seg.start[31:0] + isn_reg;
                    rbuf_wdata.len         = head_seg.len[10:0];
                    rbuf_wdata.syn         = head_seg.syn;
                    rbuf_wdata.fin         = head_seg.fin;
                    rbuf_wdata.retx        = 1'b1;
                end
            end
            S_FLIGHT:
            begin
                // status-only result when the event produced nothing
                rbuf_we = (k_reg == '0);
            end
            default:
            begin
                fifo_we = 1'b0;
            end
        endcase
    end

    // operand select for the shared adder
    always_comb
    begin
        alu_op = '0;
        case (state_reg)
            S_ACK_CMP:   alu_op = '{a: next_reg, b: ack_abs_reg, sub: 1'b1};
            S_POP_END:   alu_op = '{a: head_seg.start, b: {47'd0, head_span}, sub: 1'b0};
            S_POP_CMP:   alu_op = '{a: ack_abs_reg, b: space_reg, sub: 1'b1};
            S_ACK_MAX:   alu_op = '{a: acked_reg, b: ack_abs_reg, sub: 1'b1};
            S_FILL_INIT: alu_op = '{a: acked_reg, b: {48'd0, eff_win}, sub: 1'b0};
            S_FILL_CHK:  alu_op = '{a: right_reg, b: next_reg, sub: 1'b1};
            S_FILL_ADV:  alu_op = '{a: next_reg, b: {47'd0, span_reg}, sub: 1'b0};
            S_TICK_ADD:  alu_op = '{a: {32'd0, timer_reg}, b: {48'd0, elapsed_reg},
                                    sub: 1'b0};
            S_FLIGHT:    alu_op = '{a: next_reg, b: head_seg.start, sub: 1'b1};
            default:     alu_op = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_rto_reg  <= 16'd1000;
            isn_reg       <= '0;
            next_reg      <= '0;
            acked_reg     <= '0;
            window_reg    <= 16'd1;
            rto_reg       <= 32'd1000;
            timer_reg     <= '0;
            timer_on_reg  <= 1'b0;
            retx_reg      <= '0;
            syn_done_reg  <= 1'b0;
            fin_done_reg  <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            popped_reg    <= 1'b0;
            apply_reg     <= 1'b0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        if (cfg_index == tsw_pkg::REG_INITIAL_RTO)
                        begin
                            init_rto_reg <= cfg_data[15:0];
                        end
                        else if (cfg_index == tsw_pkg::REG_INITIAL_SEQNO)
                        begin
                            isn_reg <= cfg_data;
                        end
                    end
                    if (in_valid)
                    begin
                        ackn_reg    <= in_data.ack_number;
                        pwin_reg    <= in_data.peer_window;
                        elapsed_reg <= in_data.elapsed_ms;
                        avail_reg   <= in_data.bytes_available;
                        eof_reg     <= in_data.stream_eof;
                        k_reg       <= '0;
                        popped_reg  <= 1'b0;
                        apply_reg   <= 1'b0;
                        case (in_data.func)
                            tsw_pkg::FN_FILL:  state_reg <= S_FILL_INIT;
                            tsw_pkg::FN_ACK:   state_reg <= S_ACK_UNWRAP;
                            tsw_pkg::FN_TICK:  state_reg <= timer_on_reg ? S_TICK_ADD
                                                                         : S_FLIGHT_WAIT;
                            default:
                            begin
                                k_reg     <= tsw_pkg::RES_AW'(1);
                                state_reg <= S_FLIGHT_WAIT;
                            end
                        endcase
                    end
                end
                S_ACK_UNWRAP:
                begin
                    ack_abs_reg <= unwrapped;
                    state_reg   <= S_ACK_CMP;
                end
                S_ACK_CMP:
                begin
                    // ack beyond next is dropped
                    if (alu_res.flag)
                    begin
                        state_reg <= S_FLIGHT_WAIT;
                    end
                    else
                    begin
                        window_reg <= pwin_reg;
                        apply_reg  <= 1'b1;
                        state_reg  <= S_POP_RD;
                    end
                end
                S_POP_RD:
                begin
                    state_reg <= (count_reg == '0) ? S_ACK_MAX : S_POP_END;
                end
                S_POP_END:
                begin
                    space_reg <= alu_res.value;
                    state_reg <= S_POP_CMP;
                end
                S_POP_CMP:
                begin
                    if (alu_res.flag)
                    begin
                        state_reg <= S_ACK_MAX;
                    end
                    else
                    begin
                        head_reg   <= (head_reg == AW'(PENDING_DEPTH - 1))
                                      ? '0 : head_reg + AW'(1);
                        count_reg  <= count_reg - CW'(1);
                        popped_reg <= 1'b1;
                        state_reg  <= S_POP_RD;
                    end
                end
                S_ACK_MAX:
                begin
                    if (popped_reg)
                    begin
                        timer_reg <= '0;
                        rto_reg   <= {16'd0, init_rto_reg};
                        retx_reg  <= '0;
                    end
                    if (alu_res.flag)
                    begin
                        acked_reg <= ack_abs_reg;
                    end
                    state_reg <= S_FILL_INIT;
                end
                S_FILL_INIT:
                begin
                    right_reg <= alu_res.value;
                    state_reg <= S_FILL_CHK;
                end
                S_FILL_CHK:
                begin
                    if (!alu_res.flag && alu_res.value != '0
                        && k_reg < tsw_pkg::RES_AW'(tsw_pkg::RESULT_CAP)
                        && count_reg < CW'(PENDING_DEPTH))
                    begin
                        space_reg <= alu_res.value;
                        state_reg <= S_FILL_DO;
                    end
                    else
                    begin
                        state_reg <= S_FLIGHT_WAIT;
                    end
                end
                S_FILL_DO:
                begin
                    if (fill_end)
                    begin
                        state_reg <= S_FLIGHT_WAIT;
                    end
                    else
                    begin
                        syn_done_reg <= 1'b1;
                        if (emit_fin)
                        begin
                            fin_done_reg <= 1'b1;
                        end
                        if (syn_done_reg)
                        begin
                            avail_reg <= avail_left;
                        end
                        if (count_reg == '0)
                        begin
                            timer_reg    <= '0;
                            timer_on_reg <= 1'b1;
                        end
                        count_reg <= count_reg + CW'(1);
                        k_reg     <= k_reg + tsw_pkg::RES_AW'(1);
                        span_reg  <= emit_span;
                        stop_reg  <= emit_fin;
                        state_reg <= S_FILL_ADV;
                    end
                end
                S_FILL_ADV:
                begin
                    next_reg  <= alu_res.value;
                    state_reg <= stop_reg ? S_FLIGHT_WAIT : S_FILL_CHK;
                end
                S_TICK_ADD:
                begin
                    timer_reg <= alu_res.value[32] ? '1 : alu_res.value[31:0];
                    state_reg <= S_TICK_CMP;
                end
                S_TICK_CMP:
                begin
                    if (retx_go)
                    begin
                        timer_reg <= '0;
                        if (window_reg != '0)
                        begin
                            rto_reg <= rto_reg[31] ? '1 : {rto_reg[30:0], 1'b0};
                        end
                        if (retx_reg != '1)
                        begin
                            retx_reg <= retx_reg + 8'd1;
                        end
                        k_reg <= tsw_pkg::RES_AW'(1);
                    end
                    state_reg <= S_FLIGHT_WAIT;
                end
                S_FLIGHT_WAIT:
                begin
                    // head entry read settles here after the last fifo write
                    if (apply_reg && count_reg == '0)
                    begin
                        timer_on_reg <= 1'b0;
                    end
                    state_reg <= S_FLIGHT;
                end
                S_FLIGHT:
                begin
                    if (count_reg == '0)
                    begin
                        flight_reg <= '0;
                    end
                    else
                    begin
                        flight_reg <= (alu_res.value[63:17] != '0) ? '1
                                                                   : alu_res.value[16:0];
                    end
                    if (k_reg == '0)
                    begin
                        k_reg <= tsw_pkg::RES_AW'(1);
                    end
                    out_idx_reg <= '0;
                    state_reg   <= S_OUT_RD;
                end
                S_OUT_RD:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_OUT_SHOW;
                end
                S_OUT_SHOW:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_idx_reg == k_reg - tsw_pkg::RES_AW'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_idx_reg <= out_idx_reg + tsw_pkg::RES_AW'(1);
                            state_reg   <= S_OUT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: hw/rtl/tsw_alu.sv
// shared 64-bit add/subtract unit of the sequencer
// depends on tsw_pkg
module tsw_alu (
    input  tsw_pkg::alu_op_t  op,
    output tsw_pkg::alu_res_t res
);
    logic [64:0] sum;

    always_comb
    begin
        sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {64'd0, op.sub};
        res.value = sum[63:0];
        res.flag  = op.sub ? ~sum[64] : sum[64];
    end
endmodule

FILE: hw/rtl/tsw_ram.sv
// simple dual-port memory, registered read
// no dependencies
module tsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: hw/rtl/tsw_checker.sv
// port-level checks of the tcp sender window engine, bound to the top level
// depends on tsw_pkg and assert_macros.svh
`include "assert_macros.svh"

module tsw_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input tsw_pkg::in_item_t             in_data,
    input logic                          out_valid,
    input logic                          out_ready,
    input tsw_pkg::out_item_t            out_data,
    input logic                          cfg_ready
);
    // one event at a time: no new item while results are pending
    `TSW_NEVER(a_no_overlap, in_ready && out_valid)

    // a stalled result holds
    `TSW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))

    // an offered item holds until taken
    `TSW_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable(in_data))

    // a status-only result is always the only one of its event
    `TSW_ASSERT(a_status_last, out_valid && !out_data.has_segment |-> out_data.last)

    // an accepted item is followed by a busy block
    `TSW_ASSERT(a_busy_after_item, in_valid && in_ready |=> !in_ready && !cfg_ready)
endmodule

bind tcp_sender_window_retransmit tsw_checker u_tsw_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_ready(cfg_ready)
);
